// ===== design/ahb_clock_and_mdc_divider_select_macros.svh =====
// Assertion macros shared by the checker of the bus clock divider select block.
`ifndef AHB_CLOCK_AND_MDC_DIVIDER_SELECT_MACROS_SVH
`define AHB_CLOCK_AND_MDC_DIVIDER_SELECT_MACROS_SVH

// Checked outside reset
`define AHBCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define AHBCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ahbcd_pkg.sv =====
// Types, constants and tables of the bus clock and management divider select block.
package ahbcd_pkg;

  localparam int HzW    = 26;               // oscillator and limit registers
  localparam int BusW   = 32;               // bus clock and minimum bus register
  localparam int NW     = 9;                // PLL N field
  localparam int MW     = 6;                // PLL M field
  localparam int ProdW  = HzW + NW;         // exact source * N
  localparam int ThrW   = HzW + 1 + 7;      // (limit + 1) * divider
  localparam int NMdc   = 6;
  localparam int DivBitsDef = 5;            // quotient bits resolved per division stage
  localparam int PAddrW = 4;
  localparam int PDataW = 32;

  // Bus prescaler shifts for codes 8 to 15
  localparam logic [3:0] PrescShift [8] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};
  // Management clock dividers, in order of preference, and their range codes
  localparam logic [6:0] MdcDiv [NMdc] = '{7'd16, 7'd26, 7'd42, 7'd62, 7'd102, 7'd124};
  localparam logic [2:0] MdcCode [NMdc] = '{3'd2, 3'd3, 3'd0, 3'd1, 3'd4, 3'd5};

  // Reset values of the registers
  localparam logic [HzW-1:0]  ExtOscRst = 26'd8000000;
  localparam logic [HzW-1:0]  IntOscRst = 26'd16000000;
  localparam logic [HzW-1:0]  MdcLimRst = 26'd2375000;
  localparam logic [BusW-1:0] MinBusRst = 32'd25000000;

  // Reciprocal of three, exact for any 32-bit dividend after a shift by 33
  localparam logic [31:0] Recip3 = 32'hAAAAAAAB;

  typedef enum logic [1:0] {
    REG_EXT_OSC = 2'd0,
    REG_INT_OSC = 2'd1,
    REG_MDC_LIM = 2'd2,
    REG_MIN_BUS = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PDIV2 = 2'd0,
    PDIV4 = 2'd1,
    PDIV6 = 2'd2,
    PDIV8 = 2'd3
  } pdiv_t;

  // Register view handed to the datapath
  typedef struct packed {
    logic [HzW-1:0]             ext_osc_hz;
    logic [HzW-1:0]             int_osc_hz;
    logic [BusW-1:0]            min_bus_hz;
    logic [NMdc-1:0][ThrW-1:0]  thr;        // bus clock must stay below thr[i]
  } cfg_t;

  // Side information carried alongside the division
  typedef struct packed {
    logic [MW-1:0]  m;
    pdiv_t          pdiv;
    logic           use_pll;
    logic           m_zero;
    logic [HzW-1:0] direct_hz;
    logic [3:0]     hpre;
  } side_t;

endpackage

// ===== design/ahbcd_cfg.sv =====
// APB register file with precomputed management clock thresholds.
module ahbcd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ahbcd_pkg::PAddrW-1:0]  paddr,
  input  logic [ahbcd_pkg::PDataW-1:0]  pwdata,
  output logic [ahbcd_pkg::PDataW-1:0]  prdata,
  output logic                          pready,
  output ahbcd_pkg::cfg_t               cfg
);
  import ahbcd_pkg::*;

  logic [HzW-1:0]  ext_osc_hz;
  logic [HzW-1:0]  int_osc_hz;
  logic [HzW-1:0]  mdc_lim_hz;
  logic [BusW-1:0] min_bus_hz;
  logic [NMdc-1:0][ThrW-1:0] thr;
  logic [HzW:0]    lim_p1;
  logic            wr;
  reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ext_osc_hz <= ExtOscRst;
      int_osc_hz <= IntOscRst;
      mdc_lim_hz <= MdcLimRst;
      min_bus_hz <= MinBusRst;
    end else if (wr) begin
      case (idx)
        REG_EXT_OSC: ext_osc_hz <= pwdata[HzW-1:0];
        REG_INT_OSC: int_osc_hz <= pwdata[HzW-1:0];
        REG_MDC_LIM: mdc_lim_hz <= pwdata[HzW-1:0];
        REG_MIN_BUS: min_bus_hz <= pwdata[BusW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_EXT_OSC: prdata = PDataW'(ext_osc_hz);
      REG_INT_OSC: prdata = PDataW'(int_osc_hz);
      REG_MDC_LIM: prdata = PDataW'(mdc_lim_hz);
      REG_MIN_BUS: prdata = PDataW'(min_bus_hz);
      default:     prdata = '0;
    endcase
  end

  // floor(bus / d) <= limit  <=>  bus < (limit + 1) * d; refreshed every cycle
  assign lim_p1 = {1'b0, mdc_lim_hz} + (HzW+1)'(1);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NMdc; i++) begin
      thr[i] <= ThrW'(lim_p1) * ThrW'(MdcDiv[i]);
    end
  end

  assign cfg.ext_osc_hz = ext_osc_hz;
  assign cfg.int_osc_hz = int_osc_hz;
  assign cfg.min_bus_hz = min_bus_hz;
  assign cfg.thr        = thr;

endmodule

// ===== design/ahbcd_div.sv =====
// One stage of the restoring divider for source * N / M.
module ahbcd_div #(
  parameter int DivBits = ahbcd_pkg::DivBitsDef,
  parameter int WorkW   = ahbcd_pkg::ProdW
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [WorkW-1:0]           work_in,   // dividend bits above, quotient bits below
  input  logic [ahbcd_pkg::MW-1:0]   rem_in,
  input  ahbcd_pkg::side_t           side_in,
  output logic [WorkW-1:0]           work_out,
  output logic [ahbcd_pkg::MW-1:0]   rem_out,
  output ahbcd_pkg::side_t           side_out
);
  import ahbcd_pkg::*;

  logic [WorkW-1:0] w;
  logic [MW-1:0]    r;

  // DivBits shift-and-subtract steps, remainder kept below M when M is nonzero
  always_comb begin
    logic [MW:0] t;
    w = work_in;
    r = rem_in;
    for (int k = 0; k < DivBits; k++) begin
      t = {r, w[WorkW-1]};
      w = {w[WorkW-2:0], 1'b0};
      if (t >= {1'b0, side_in.m}) begin
        t    = t - {1'b0, side_in.m};
        w[0] = 1'b1;
      end
      r = t[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_out <= w;
      rem_out  <= r;
      side_out <= side_in;
    end
  end

endmodule

// ===== design/ahb_clock_and_mdc_divider_select.sv =====
// Top level: bus clock computation and management clock divider selection pipeline.
//
//  Channel | Direction | Handshake              | Payload
//  s_*     | in        | s_tvalid / s_tready    | clock_cfg_word, pll_cfg_word
//  m_*     | out       | m_tvalid / m_tready    | bus_hz, divider_code, divider_status
//  APB     | in        | psel, penable, pwrite  | four registers at 0x0..0xC, read as 32 bits
//
// One transfer per cycle sustained while the receiver takes results; the radix-2
// divider for source * N / M is spread over NDiv stages, with the default of five
// quotient bits per stage.
// Reset clears every stage valid bit; the registers return to their defaults.
// Each stage holds while it is full and the one after it cannot take data, so an
// empty stage always accepts and back-pressure only reaches the input when all are full.
module ahb_clock_and_mdc_divider_select #(
  parameter int DivBits = ahbcd_pkg::DivBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // [31:0] clock_cfg_word, [63:32] pll_cfg_word
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,   // [31:0] bus_hz, [34:32] divider_code,
                                                   // [36:35] divider_status, [39:37] zero
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ahbcd_pkg::PAddrW-1:0]  paddr,
  input  logic [ahbcd_pkg::PDataW-1:0]  pwdata,
  output logic [ahbcd_pkg::PDataW-1:0]  prdata,
  output logic                          pready
);
  import ahbcd_pkg::*;

  localparam int NDiv   = (ProdW + DivBits - 1) / DivBits;
  localparam int WorkW  = NDiv * DivBits;
  localparam int NStage = NDiv + 4;   // entry, divider stages, P divide, prescale, select

  cfg_t cfg;

  ahbcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage valid bits and per-stage load enables
  logic [NStage-1:0] vld;
  logic [NStage-1:0] rdy;

  always_comb begin
    rdy[NStage-1] = ~vld[NStage-1] | m_tready;
    for (int k = NStage - 2; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NStage; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NStage-1];

  // Entry stage: decode, pick sources, form source * N
  logic [31:0]    cfg_w;
  logic [31:0]    pll_w;
  logic [HzW-1:0] pll_src;
  logic [ProdW-1:0] prod;
  side_t          side0;

  assign cfg_w   = s_tdata[31:0];
  assign pll_w   = s_tdata[63:32];
  assign pll_src = pll_w[22] ? cfg.ext_osc_hz : cfg.int_osc_hz;
  assign prod    = {{NW{1'b0}}, pll_src} * {{HzW{1'b0}}, pll_w[14:6]};

  always_comb begin
    side0.m         = pll_w[5:0];
    side0.pdiv      = pdiv_t'(pll_w[17:16]);
    side0.use_pll   = ~cfg_w[2] & cfg_w[3];
    side0.m_zero    = ~cfg_w[2] & cfg_w[3] & (pll_w[5:0] == '0);
    side0.direct_hz = cfg_w[2] ? cfg.ext_osc_hz : cfg.int_osc_hz;
    side0.hpre      = cfg_w[7:4];
  end

  logic [NDiv:0][WorkW-1:0] dwork;
  logic [NDiv:0][MW-1:0]    drem;
  side_t                    dside [NDiv+1];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dwork[0] <= WorkW'(prod);
      drem[0]  <= '0;
      dside[0] <= side0;
    end
  end

  // Divider stages
  for (genvar g = 0; g < NDiv; g++) begin : g_div
    ahbcd_div #(
      .DivBits (DivBits),
      .WorkW   (WorkW)
    ) u_div (
      .clk      (clk),
      .en       (rdy[g+1]),
      .work_in  (dwork[g]),
      .rem_in   (drem[g]),
      .side_in  (dside[g]),
      .work_out (dwork[g+1]),
      .rem_out  (drem[g+1]),
      .side_out (dside[g+1])
    );
  end

  // P divide: shifts for 2, 4, 8; half times reciprocal of three for 6
  logic [31:0] vco;
  logic [31:0] pshift;
  logic [31:0] p_shift;
  logic [62:0] p_mul;
  side_t       p_side;

  assign vco = dwork[NDiv][31:0];

  always_comb begin
    case (dside[NDiv].pdiv)
      PDIV2:   pshift = vco >> 1;
      PDIV4:   pshift = vco >> 2;
      PDIV8:   pshift = vco >> 3;
      default: pshift = vco >> 1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[NDiv+1]) begin
      p_shift <= pshift;
      p_mul   <= {32'b0, vco[31:1]} * {31'b0, Recip3};
      p_side  <= dside[NDiv];
    end
  end

  // Prescale: choose the source, apply the bus prescaler shift
  logic [31:0] pll_hz;
  logic [31:0] raw_hz;
  logic [31:0] bus_q;
  logic        mz_q;

  assign pll_hz = (p_side.pdiv == PDIV6) ? 32'(p_mul[62:33]) : p_shift;

  always_comb begin
    if (p_side.m_zero) begin
      raw_hz = '0;
    end else if (p_side.use_pll) begin
      raw_hz = pll_hz;
    end else begin
      raw_hz = 32'(p_side.direct_hz);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NDiv+2]) begin
      bus_q <= p_side.hpre[3] ? (raw_hz >> PrescShift[p_side.hpre[2:0]]) : raw_hz;
      mz_q  <= p_side.m_zero;
    end
  end

  // Divider select: first divider whose threshold lies above the bus clock
  logic [2:0] code_c;
  status_t    stat_c;

  always_comb begin
    code_c = '0;
    stat_c = ST_HIGH;
    if (mz_q || (bus_q < cfg.min_bus_hz)) begin
      stat_c = ST_LOW;
    end else begin
      for (int i = NMdc - 1; i >= 0; i--) begin
        if (ThrW'(bus_q) < cfg.thr[i]) begin
          code_c = MdcCode[i];
          stat_c = ST_OK;
        end
      end
    end
  end

  logic [31:0] out_hz;
  logic [2:0]  out_code;
  status_t     out_stat;

  always_ff @(posedge clk) begin
    if (rdy[NStage-1]) begin
      out_hz   <= bus_q;
      out_code <= code_c;
      out_stat <= stat_c;
    end
  end

  assign m_tdata = {3'b000, out_stat, out_code, out_hz};

endmodule

// ===== design/ahbcd_checker.sv =====
// Port-level checker for the divider select block, bound to the top level.
`include "ahb_clock_and_mdc_divider_select_macros.svh"

module ahbcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import ahbcd_pkg::*;

  logic ok;
  logic code_zero;
  logic fields_ok;
  logic stall;
  assign ok        = (m_tdata[36:35] == ST_OK);
  assign code_zero = (m_tdata[34:32] == 3'd0);
  assign fields_ok = (m_tdata[36:35] != 2'd3) && (m_tdata[34:32] <= 3'd5) &&
                     (m_tdata[39:37] == 3'd0);
  assign stall     = m_tvalid && !m_tready;

  // A result that is not ok carries divider code zero
  `AHBCD_ASSERT(a_code_zero, m_tvalid && !ok |-> code_zero, "code set without ok status")
  // Status and code stay within their defined ranges and the padding bits are zero
  `AHBCD_ASSERT(a_ranges, m_tvalid |-> fields_ok, "result field out of range")
  // Reset empties the pipeline
  `AHBCD_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")
  // A stalled result holds until it is taken
  `AHBCD_ASSERT(a_hold, stall |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind ahb_clock_and_mdc_divider_select ahbcd_checker u_ahbcd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/tb_ahb_clock_and_mdc_divider_select.sv =====
// Testbench for the bus clock and management clock divider select block.
`timescale 1ns / 1ps

module tb_ahb_clock_and_mdc_divider_select;
  import ahbcd_pkg::*;

  localparam int ItemsPerPhase = 138;
  localparam int NPhases       = 6;
  localparam int HoldCycles    = 200;
  localparam int DrainCycles   = 24;

  // Prescaler shifts for codes 8..15, management dividers and their range codes
  localparam int unsigned HpreShift [8] = '{1, 2, 3, 4, 6, 7, 8, 9};
  localparam int unsigned MdcDivide [6] = '{16, 26, 42, 62, 102, 124};
  localparam int unsigned MdcRange  [6] = '{2, 3, 0, 1, 4, 5};

  typedef struct {
    logic [31:0] bus_hz;
    logic [2:0]  code;
    status_t     status;
  } divsel_t;

  // Shadow registers, bus clock prediction and the queue of expected results
  class divider_choice_board;
    logic [25:0] ext_hz;
    logic [25:0] rc_hz;
    logic [25:0] mdc_lim_hz;
    logic [31:0] min_hz;
    divsel_t     expected_q[$];
    int          errors;

    function new();
      ext_hz     = 26'd8000000;
      rc_hz      = 26'd16000000;
      mdc_lim_hz = 26'd2375000;
      min_hz     = 32'd25000000;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_EXT_OSC: ext_hz     = val[25:0];
        REG_INT_OSC: rc_hz      = val[25:0];
        REG_MDC_LIM: mdc_lim_hz = val[25:0];
        REG_MIN_BUS: min_hz     = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(reg_idx_t idx);
      case (idx)
        REG_EXT_OSC: return {6'd0, ext_hz};
        REG_INT_OSC: return {6'd0, rc_hz};
        REG_MDC_LIM: return {6'd0, mdc_lim_hz};
        default:     return min_hz;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Work out the bus clock and divider choice for one register snapshot
    function void note_snapshot(logic [31:0] cw, logic [31:0] pw);
      divsel_t     e;
      logic [5:0]  m;
      logic [8:0]  n;
      logic [3:0]  pdiv;
      logic [25:0] src;
      logic [63:0] vco;
      logic [3:0]  hpre;
      bit          m_zero;
      m_zero = 1'b0;
      e.code = 3'd0;
      if (cw[2]) begin
        e.bus_hz = {6'd0, ext_hz};
      end else if (cw[3]) begin
        m    = pw[5:0];
        n    = pw[14:6];
        pdiv = ({2'b00, pw[17:16]} + 4'd1) << 1;
        src  = pw[22] ? ext_hz : rc_hz;
        if (m == 6'd0) begin
          m_zero   = 1'b1;
          e.bus_hz = 32'd0;
        end else begin
          // exact product and quotient, then keep the low 32 bits
          vco      = (64'(src) * 64'(n)) / 64'(m);
          e.bus_hz = vco[31:0] / {28'd0, pdiv};
        end
      end else begin
        e.bus_hz = {6'd0, rc_hz};
      end
      hpre = cw[7:4];
      if (hpre[3]) e.bus_hz = e.bus_hz >> HpreShift[hpre[2:0]];
      if (m_zero || e.bus_hz < min_hz) begin
        e.status = ST_LOW;
      end else begin
        e.status = ST_HIGH;
        for (int i = 0; i < 6; i++) begin
          if (e.bus_hz / MdcDivide[i] <= {6'd0, mdc_lim_hz}) begin
            e.code   = 3'(MdcRange[i]);
            e.status = ST_OK;
            break;
          end
        end
      end
      expected_q.push_back(e);
    endfunction

    task check_result(logic [39:0] td);
      divsel_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", td));
        return;
      end
      e = expected_q.pop_front();
      if (td[31:0] !== e.bus_hz)
        report($sformatf("bus_hz %0d, expected %0d", td[31:0], e.bus_hz));
      if (td[34:32] !== e.code)
        report($sformatf("divider_code %0d, expected %0d", td[34:32], e.code));
      if (td[36:35] !== e.status)
        report($sformatf("divider_status %0d, expected %0d", td[36:35], e.status));
      if (td[39:37] !== 3'd0)
        report($sformatf("padding bits %b not zero", td[39:37]));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [31:0] clock_cfg_word, [63:32] pll_cfg_word
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [31:0] bus_hz, [34:32] divider_code, [36:35] divider_status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic        pready;

  bit hold_out;   // receiver holds off for a long stretch
  bit steady;     // no idling on either side

  divider_choice_board book = new();

  ahb_clock_and_mdc_divider_select dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pll_word(int m, int n, pdiv_t p, bit ext_src);
    logic [31:0] w;
    w        = '0;
    w[5:0]   = 6'(m);
    w[14:6]  = 9'(n);
    w[17:16] = p;
    w[22]    = ext_src;
    return w;
  endfunction

  // Offer one snapshot, after an optional gap, and wait for the transfer
  task automatic offer(input logic [31:0] cw, input logic [31:0] pw);
    int gap;
    gap = (hold_out || steady) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pw, cw};
    do @(posedge clk); while (!s_tready);
    book.note_snapshot(cw, pw);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Setup and access cycles; the bus is left selected for a following transfer
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    book.set_reg(idx, val);
  endtask

  task automatic reg_read(input reg_idx_t idx, output logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    val = prdata;
  endtask

  // Write all four registers, then read them back
  task automatic program_regs(input logic [31:0] ext, input logic [31:0] rc,
                              input logic [31:0] lim, input logic [31:0] minb);
    logic [31:0] rd;
    reg_write(REG_EXT_OSC, ext);
    reg_write(REG_INT_OSC, rc);
    reg_write(REG_MDC_LIM, lim);
    reg_write(REG_MIN_BUS, minb);
    for (int i = 0; i < 4; i++) begin
      reg_read(reg_idx_t'(i), rd);
      if (rd !== book.reg_value(reg_idx_t'(i)))
        book.report($sformatf("register %0d reads %h, expected %h", i, rd,
                              book.reg_value(reg_idx_t'(i))));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random snapshot: source spread evenly, a few zero M, prescaler often off
  task automatic offer_random();
    logic [31:0] cw;
    logic [31:0] pw;
    cw = $urandom;
    pw = $urandom;
    case ($urandom_range(0, 2))
      0:       cw[2]   = 1'b1;
      1:       cw[3:2] = 2'b10;
      default: cw[3:2] = 2'b00;
    endcase
    if ($urandom_range(0, 19) == 0) pw[5:0] = 6'd0;
    if ($urandom_range(0, 1) == 1) cw[7] = 1'b0;
    offer(cw, pw);
  endtask

  task automatic run_directed();
    offer(32'h0000_0000, 32'h0000_0000);
    offer(32'h0000_0004, 32'h0000_0000);
    offer(32'h0000_000C, $urandom);
    // zero M with the PLL selected
    offer(32'h0000_0008, pll_word(0, 100, PDIV2, 1'b1));
    offer(32'h0000_0008, pll_word(8, 336, PDIV4, 1'b0));
    offer(32'h0000_0008, pll_word(4, 50, PDIV2, 1'b0));
    offer(32'h0000_0008, pll_word(4, 50, PDIV4, 1'b0));
    offer(32'h0000_0008, pll_word(4, 50, PDIV6, 1'b0));
    offer(32'h0000_0008, pll_word(4, 50, PDIV8, 1'b0));
    // source * N / M beyond 32 bits
    offer(32'h0000_0008, pll_word(1, 511, PDIV2, 1'b0));
    // no divider fits
    offer(32'h0000_0008, pll_word(1, 40, PDIV2, 1'b0));
    // prescaler code just below the dividing range, then every dividing code
    for (int h = 7; h < 16; h++)
      offer(32'h0000_0008 | (32'(h) << 4), pll_word(8, 336, PDIV4, 1'b0));
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFFB, 32'hFFFF_FFFF);
  endtask

  // Receiver: random stalls, steady stretches and one long hold
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_out = 1'b0;
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_result(m_tdata);
  end

  // Stimulus
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    hold_out = 1'b0;
    steady   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NPhases; ph++) begin
      // reset values first, then the two extremes, then random settings
      case (ph)
        0: run_directed();
        1: begin
          drain();
          program_regs(32'd67108863, 32'd1000000, 32'd1, 32'd0);
        end
        2: begin
          drain();
          program_regs(32'd1000000, 32'd67108863, 32'd67108863, 32'hFFFF_FFFF);
        end
        default: begin
          drain();
          program_regs($urandom_range(1000000, 67108863), $urandom_range(1000000, 67108863),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 67108863)
                                                   : $urandom_range(1, 4000000),
                       $urandom_range(0, 60000000));
        end
      endcase
      for (int k = 0; k < ItemsPerPhase; k++) begin
        steady = ((k / 40) % 4 == 3);
        if (ph == 1 && k == 30) hold_out = 1'b1;
        offer_random();
      end
      steady = 1'b0;
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (book.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/ahbcd_pkg.sv
design/ahbcd_cfg.sv
design/ahbcd_div.sv
design/ahb_clock_and_mdc_divider_select.sv
design/ahbcd_checker.sv
sim/tb_ahb_clock_and_mdc_divider_select.sv
